// ===== src/hle_pkg.sv =====
package hle_pkg;

  // Frame counter width
  localparam int CNT_W = 16;
  // Most beats one item can cause: stuffed byte, stuffed FCS pair, flag
  localparam int MAX_RUN = 7;
  localparam int RUN_IDX_W = $clog2(MAX_RUN + 1);

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] XON_BYTE = 8'h11;
  localparam logic [7:0] XOFF_BYTE = 8'h13;
  localparam logic [7:0] ESC_XOR = 8'h20;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1280;
  localparam logic [15:0] OUTPUT_CAPACITY_RST = 16'hFFFF;

  // Register indexes
  localparam logic CFG_MAX_PAYLOAD = 1'b0;
  localparam logic CFG_OUTPUT_CAPACITY = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CNT_W:0] sum_t;
  typedef logic [RUN_IDX_W-1:0] run_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic has_data;
    logic end_of_frame;
  } item_t;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [15:0] output_capacity;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic done;
    logic err;
  } beat_t;

  typedef struct packed {
    beat_t [MAX_RUN-1:0] beats;
    run_idx_t count;
  } run_t;

  function automatic logic reserved_byte(logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE) || (b == XON_BYTE) || (b == XOFF_BYTE);
  endfunction

  function automatic logic [1:0] stuffed_len(logic [7:0] b);
    return reserved_byte(b) ? 2'd2 : 2'd1;
  endfunction

  // CRC-16/X-25, reflected, one byte
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic run_t put_beat(run_t r, logic [7:0] d, logic done, logic err);
    run_t o;
    o = r;
    o.beats[r.count] = '{data: d, done: done, err: err};
    o.count = r.count + run_idx_t'(1);
    return o;
  endfunction

  function automatic run_t put_escaped(run_t r, logic [7:0] b);
    run_t o;
    if (reserved_byte(b)) begin
      o = put_beat(r, ESC_BYTE, 1'b0, 1'b0);
      o = put_beat(o, b ^ ESC_XOR, 1'b0, 1'b0);
    end else begin
      o = put_beat(r, b, 1'b0, 1'b0);
    end
    return o;
  endfunction

endpackage

// ===== src/hle_encode.sv =====
module hle_encode (
  input  logic          clk,
  input  logic          rst,
  input  hle_pkg::item_t item,
  input  hle_pkg::cfg_t  cfg,
  input  logic          advance,
  output hle_pkg::run_t  run
);

  logic [15:0] crc_accum, crc_accum_next;
  hle_pkg::cnt_t out_count, out_count_next;
  hle_pkg::cnt_t payload_count, payload_count_next;
  logic failed, failed_next;

  always_comb begin
    logic [1:0] data_need;
    logic [2:0] tail_need;
    logic [15:0] crc1, fcs;
    hle_pkg::cnt_t out1, pay1;
    logic pay_over, cap_over;

    run = '0;
    crc_accum_next = crc_accum;
    out_count_next = out_count;
    payload_count_next = payload_count;
    failed_next = failed;

    data_need = hle_pkg::stuffed_len(item.data_byte);
    pay_over = (hle_pkg::sum_t'(payload_count) + hle_pkg::sum_t'(1))
               > hle_pkg::sum_t'(cfg.max_payload);
    cap_over = (hle_pkg::sum_t'(out_count) + hle_pkg::sum_t'(data_need))
               > hle_pkg::sum_t'(cfg.output_capacity);
    crc1 = crc_accum;
    out1 = out_count;
    pay1 = payload_count;
    fcs = '0;
    tail_need = '0;

    if (failed) begin
      // rest of a failed frame is swallowed
      if (item.end_of_frame) begin
        crc_accum_next = hle_pkg::CRC_INIT;
        out_count_next = '0;
        payload_count_next = '0;
        failed_next = 1'b0;
      end
    end else if (item.has_data && (pay_over || cap_over)) begin
      run = hle_pkg::put_beat(run, 8'h00, item.end_of_frame, 1'b1);
      if (item.end_of_frame) begin
        crc_accum_next = hle_pkg::CRC_INIT;
        out_count_next = '0;
        payload_count_next = '0;
      end else begin
        failed_next = 1'b1;
      end
    end else begin
      if (item.has_data) begin
        run = hle_pkg::put_escaped(run, item.data_byte);
        crc1 = hle_pkg::crc_feed(crc_accum, item.data_byte);
        pay1 = payload_count + hle_pkg::cnt_t'(1);
        out1 = out_count + hle_pkg::cnt_t'(data_need);
      end
      if (item.end_of_frame) begin
        fcs = ~crc1;
        tail_need = 3'(hle_pkg::stuffed_len(fcs[7:0])) +
                    3'(hle_pkg::stuffed_len(fcs[15:8])) + 3'd1;
        if ((hle_pkg::sum_t'(out1) + hle_pkg::sum_t'(tail_need))
            > hle_pkg::sum_t'(cfg.output_capacity)) begin
          run = hle_pkg::put_beat(run, 8'h00, 1'b1, 1'b1);
        end else begin
          run = hle_pkg::put_escaped(run, fcs[7:0]);
          run = hle_pkg::put_escaped(run, fcs[15:8]);
          run = hle_pkg::put_beat(run, hle_pkg::FLAG_BYTE, 1'b1, 1'b0);
        end
        crc_accum_next = hle_pkg::CRC_INIT;
        out_count_next = '0;
        payload_count_next = '0;
      end else begin
        crc_accum_next = crc1;
        out_count_next = out1;
        payload_count_next = pay1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= hle_pkg::CRC_INIT;
      out_count <= '0;
      payload_count <= '0;
      failed <= 1'b0;
    end else if (advance) begin
      crc_accum <= crc_accum_next;
      out_count <= out_count_next;
      payload_count <= payload_count_next;
      failed <= failed_next;
    end
  end

endmodule

// ===== src/hle_drain.sv =====
module hle_drain (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  hle_pkg::run_t  run,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic          frame_done,
  output logic          frame_error
);

  hle_pkg::run_t held;
  hle_pkg::run_idx_t idx;
  logic held_valid;
  hle_pkg::beat_t cur;

  assign cur = held.beats[idx];
  assign last_of_run = (idx == (held.count - hle_pkg::run_idx_t'(1)));
  assign free = !held_valid || (last_of_run && out_ready);
  assign out_valid = held_valid;
  assign out_byte = cur.data;
  assign frame_done = cur.done;
  assign frame_error = cur.err;

  always_ff @(posedge clk) begin
    if (load) begin
      held <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      held_valid <= 1'b1;
      idx <= '0;
    end else if (held_valid && out_ready) begin
      if (last_of_run) begin
        held_valid <= 1'b0;
      end else begin
        idx <= idx + hle_pkg::run_idx_t'(1);
      end
    end
  end

endmodule

// ===== src/hdlc_lite_frame_encoder.sv =====
// HDLC-lite frame encoder: byte stuffing plus CRC-16/X-25 FCS.
// Input channel (in_valid/in_ready): one beat per item carrying data_byte,
//   has_data and end_of_frame. has_data=0 with end_of_frame=0 is an idle item.
// Output channel (out_valid/out_ready): one beat per encoded line byte, with
//   last_of_run on the final beat an item caused, frame_done on the flag (or
//   on an error beat at frame end), frame_error on an error beat (out_byte 0).
// Config port (cfg_we/cfg_index/cfg_data): index 0 max_payload, index 1
//   output_capacity; write only while the block is idle.
// Pipeline: an accepted item passes through the input register, then the
//   result register, before its first beat reaches the output port.
// Throughput: one item per cycle while each item makes at most one beat and
//   out_ready is high; an item making k beats holds the result register until
//   all k are taken (k up to 7: escaped byte, escaped FCS pair, flag). Items
//   with no beats leave the input register without touching the result register.
// Stall: when out_ready is low the result register holds its beat, the
//   input register fills and in_ready drops; nothing is lost.
// Reset: clears CRC (to 0xFFFF), frame counters, error state, both pipeline
//   valids; max_payload returns to 1280, output_capacity to 65535.
module hdlc_lite_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_data,
  input  logic        end_of_frame,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        frame_done,
  output logic        frame_error,
  // config writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  hle_pkg::cfg_t cfg;
  hle_pkg::item_t item;      // input register payload
  logic item_valid;
  hle_pkg::run_t run;
  logic free;
  logic advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload <= hle_pkg::MAX_PAYLOAD_RST;
      cfg.output_capacity <= hle_pkg::OUTPUT_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hle_pkg::CFG_MAX_PAYLOAD: cfg.max_payload <= cfg_data;
        hle_pkg::CFG_OUTPUT_CAPACITY: cfg.output_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // item leaves the input register when it makes no beats or the result
  // register frees up this cycle
  assign advance = item_valid && ((run.count == '0) || free);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{data_byte: data_byte, has_data: has_data, end_of_frame: end_of_frame};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  hle_encode u_encode (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cfg     (cfg),
    .advance (advance),
    .run     (run)
  );

  hle_drain u_drain (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && (run.count != '0)),
    .run         (run),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .frame_done  (frame_done),
    .frame_error (frame_error)
  );

endmodule

// ===== sim/hdlc_lite_frame_encoder_tb.sv =====
`timescale 1ns / 1ps

module hdlc_lite_frame_encoder_tb;

  // quiet cycles after the line empties: covers items that make no beat
  localparam int SETTLE_CYC = 8;
  localparam int RAND_ITEMS = 300;
  localparam logic [7:0] RSV_BYTES [4] = '{hle_pkg::FLAG_BYTE, hle_pkg::ESC_BYTE,
                                           hle_pkg::XON_BYTE, hle_pkg::XOFF_BYTE};
  // short names for the directed table
  localparam logic [7:0] FLAG = hle_pkg::FLAG_BYTE;
  localparam logic [7:0] ESC = hle_pkg::ESC_BYTE;
  localparam logic REG_PAY = hle_pkg::CFG_MAX_PAYLOAD;
  localparam logic REG_CAP = hle_pkg::CFG_OUTPUT_CAPACITY;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic has_data = 1'b0;
  logic end_of_frame = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic last_of_run;
  logic frame_done;
  logic frame_error;
  logic cfg_we = 1'b0;
  logic cfg_index = hle_pkg::CFG_MAX_PAYLOAD;
  logic [15:0] cfg_data = 16'h0000;

  hdlc_lite_frame_encoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .has_data     (has_data),
    .end_of_frame (end_of_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done),
    .frame_error  (frame_error),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Expected line beats
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] octet;
    logic last;
    logic done;
    logic err;
  } line_beat_t;

  line_beat_t item_run[$];   // beats of the item just accepted
  line_beat_t line_q[$];     // beats still owed by the DUT, oldest first
  line_beat_t head_beat;

  // encoder shadow: registers plus per-frame state
  logic [15:0] lim_payload;
  logic [15:0] lim_output;
  logic [15:0] fcs_run;
  int pay_cnt;
  int line_cnt;
  logic frame_dead;

  // stats
  int n_fail = 0;
  int n_beats = 0;
  int n_frames = 0;
  int n_errs = 0;
  int n_items = 0;
  int n_regs = 0;
  int snd_idle = 0;
  int rcv_idle = 0;

  function automatic line_beat_t mk_beat(logic [7:0] octet, logic last, logic done,
                                         logic err);
    line_beat_t bt;
    bt.octet = octet;
    bt.last = last;
    bt.done = done;
    bt.err = err;
    return bt;
  endfunction

  function automatic logic rsv_octet(logic [7:0] b);
    for (int k = 0; k < 4; k++)
      if (RSV_BYTES[k] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int stuff_cost(logic [7:0] b);
    return rsv_octet(b) ? 2 : 1;
  endfunction

  // CRC-16/X-25, LSB first, one octet
  function automatic logic [15:0] crc_x25_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      r = r[0] ? ((r >> 1) ^ hle_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void queue_stuffed(logic [7:0] b);
    if (rsv_octet(b)) begin
      item_run.push_back(mk_beat(hle_pkg::ESC_BYTE, 1'b0, 1'b0, 1'b0));
      item_run.push_back(mk_beat(b ^ hle_pkg::ESC_XOR, 1'b0, 1'b0, 1'b0));
    end else begin
      item_run.push_back(mk_beat(b, 1'b0, 1'b0, 1'b0));
    end
  endfunction

  function automatic void frame_reset();
    fcs_run = hle_pkg::CRC_INIT;
    pay_cnt = 0;
    line_cnt = 0;
    frame_dead = 1'b0;
  endfunction

  // Beats one input item causes; leaves them in item_run.
  function automatic void encode_item(logic [7:0] d, logic h, logic e);
    logic [15:0] fcs;
    line_beat_t tail;
    item_run = {};
    // dropped frame: swallow everything up to and including the frame end
    if (frame_dead) begin
      if (e) frame_reset();
      return;
    end
    if (h) begin
      if (pay_cnt + 1 > int'(lim_payload) ||
          line_cnt + stuff_cost(d) > int'(lim_output)) begin
        item_run.push_back(mk_beat(8'h00, 1'b1, e, 1'b1));
        if (e) frame_reset();
        else frame_dead = 1'b1;
        return;
      end
      line_cnt += stuff_cost(d);
      queue_stuffed(d);
      fcs_run = crc_x25_byte(fcs_run, d);
      pay_cnt++;
    end
    if (e) begin
      fcs = ~fcs_run;
      // trailer goes out whole or not at all
      if (line_cnt + stuff_cost(fcs[7:0]) + stuff_cost(fcs[15:8]) + 1 > int'(lim_output)) begin
        item_run.push_back(mk_beat(8'h00, 1'b0, 1'b1, 1'b1));
      end else begin
        queue_stuffed(fcs[7:0]);
        queue_stuffed(fcs[15:8]);
        item_run.push_back(mk_beat(hle_pkg::FLAG_BYTE, 1'b0, 1'b1, 1'b0));
      end
      frame_reset();
    end
    if (item_run.size() != 0) begin
      tail = item_run.pop_back();
      tail.last = 1'b1;
      item_run.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. n_exp < 0: beats come from the shadow encoder;
  // otherwise octs/done/err give the beats by hand (done/err on the last one).
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [7:0] dat;
    logic has;
    logic eof;
    logic sel;
    logic [15:0] val;
    int n_exp;
    logic [0:2][7:0] octs;
    logic done;
    logic err;
  } step_row_t;

  localparam int N_DIR = 32;
  localparam step_row_t DIR_ROWS [N_DIR] = '{
    // reset limits; empty frame -> FCS 0000 + flag
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0, 3, {8'h00, 8'h00, FLAG}, 1'b1, 1'b0},
    '{ROW_ITEM, 8'h00, 1'b1, 1'b0, 1'b0, 16'h0, 1, {8'h00, 8'h00, 8'h00}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'hFF, 1'b1, 1'b0, 1'b0, 16'h0, 1, {8'hFF, 8'h00, 8'h00}, 1'b0, 1'b0},
    // all four escaped octets
    '{ROW_ITEM, 8'h7E, 1'b1, 1'b0, 1'b0, 16'h0, 2, {ESC, 8'h5E, 8'h00}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h7D, 1'b1, 1'b0, 1'b0, 16'h0, 2, {ESC, 8'h5D, 8'h00}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h11, 1'b1, 1'b0, 1'b0, 16'h0, 2, {ESC, 8'h31, 8'h00}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h13, 1'b1, 1'b0, 1'b0, 16'h0, 2, {ESC, 8'h33, 8'h00}, 1'b0, 1'b0},
    // idle item, junk on data
    '{ROW_ITEM, 8'hA5, 1'b0, 1'b0, 1'b0, 16'h0, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h55, 1'b1, 1'b1, 1'b0, 16'h0, -1, 24'h0, 1'b0, 1'b0},
    // no payload allowed
    '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_PAY, 16'h0000, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 1'b1, 1'b0, 1'b0, 16'h0, 1, 24'h0, 1'b0, 1'b1},
    '{ROW_ITEM, 8'h7E, 1'b1, 1'b0, 1'b0, 16'h0, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 1'b1, 1'b1, 1'b0, 16'h0, 1, 24'h0, 1'b1, 1'b1},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0, 3, {8'h00, 8'h00, FLAG}, 1'b1, 1'b0},
    // no line bytes allowed
    '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_PAY, 16'hFFFF, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_CAP, 16'h0000, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0, 1, 24'h0, 1'b1, 1'b1},
    '{ROW_ITEM, 8'h41, 1'b1, 1'b0, 1'b0, 16'h0, 1, 24'h0, 1'b0, 1'b1},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0, 0, 24'h0, 1'b0, 1'b0},
    // trailer fits only if unescaped
    '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_CAP, 16'd4, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 1'b1, 1'b0, 1'b0, 16'h0, 1, {8'h41, 8'h00, 8'h00}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0, -1, 24'h0, 1'b0, 1'b0},
    // payload octet goes, trailer refused behind it
    '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_CAP, 16'd3, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 1'b1, 1'b1, 1'b0, 16'h0, 2, {8'h41, 8'h00, 8'h00}, 1'b1, 1'b1},
    // third payload octet over the limit
    '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_PAY, 16'd2, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_REG, 8'h00, 1'b0, 1'b0, REG_CAP, 16'hFFFF, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b0, 1'b0, 16'h0, 1, {8'h01, 8'h00, 8'h00}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h80, 1'b1, 1'b0, 1'b0, 16'h0, 1, {8'h80, 8'h00, 8'h00}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h7E, 1'b1, 1'b0, 1'b0, 16'h0, 1, 24'h0, 1'b0, 1'b1},
    '{ROW_ITEM, 8'h22, 1'b1, 1'b1, 1'b0, 16'h0, 0, 24'h0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0, 3, {8'h00, 8'h00, FLAG}, 1'b1, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Input side. in_valid is only raised here; whoever runs next after an
  // accepted beat lowers it in the same step, so it never gets two updates.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] d, input logic h, input logic e,
                           input int n_exp = -1, input logic [0:2][7:0] octs = '0,
                           input logic t_done = 1'b0, input logic t_err = 1'b0);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    has_data <= h;
    end_of_frame <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge
    encode_item(d, h, e);
    if (n_exp >= 0) begin
      item_run = {};
      for (int k = 0; k < n_exp; k++)
        item_run.push_back(mk_beat(octs[k], k == n_exp - 1, (k == n_exp - 1) && t_done,
                                   (k == n_exp - 1) && t_err));
    end
    foreach (item_run[k]) line_q.push_back(item_run[k]);
    if (h || e) n_items++;
  endtask

  // hold the sender off until every owed beat is out, then let the pipe empty
  task automatic drain_line();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // only called with the DUT quiet
  task automatic write_reg(input logic sel, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == hle_pkg::CFG_MAX_PAYLOAD) lim_payload = val;
    else lim_output = val;
    n_regs++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure, every beat checked against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (line_q.size() == 0) begin
        $error("beat with nothing owed: out_byte %02h", out_byte);
        n_fail++;
      end else begin
        head_beat = line_q.pop_front();
        if (out_byte !== head_beat.octet) begin
          $error("out_byte: expected %02h, got %02h", head_beat.octet, out_byte);
          n_fail++;
        end
        if (last_of_run !== head_beat.last) begin
          $error("last_of_run: expected %0b, got %0b", head_beat.last, last_of_run);
          n_fail++;
        end
        if (frame_done !== head_beat.done) begin
          $error("frame_done: expected %0b, got %0b", head_beat.done, frame_done);
          n_fail++;
        end
        if (frame_error !== head_beat.err) begin
          $error("frame_error: expected %0b, got %0b", head_beat.err, frame_error);
          n_fail++;
        end
        n_beats++;
        if (head_beat.done) n_frames++;
        if (head_beat.err) n_errs++;
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] ha, hb, hc, pick;
    logic [15:0] c2, c3;
    logic found, tail_eof;
    int goal, len, frm;

    lim_payload = hle_pkg::MAX_PAYLOAD_RST;
    lim_output = hle_pkg::OUTPUT_CAPACITY_RST;
    frame_reset();
    snd_idle = 18;
    rcv_idle = 65;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, field extremes, escapes, limits at zero
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].kind == ROW_REG) begin
        drain_line();
        write_reg(DIR_ROWS[r].sel, DIR_ROWS[r].val);
      end else begin
        send_item(DIR_ROWS[r].dat, DIR_ROWS[r].has, DIR_ROWS[r].eof, DIR_ROWS[r].n_exp,
                  DIR_ROWS[r].octs, DIR_ROWS[r].done, DIR_ROWS[r].err);
      end
    end

    // random: three idle mixes, each with its own limits
    for (int ph = 0; ph < 3; ph++) begin
      drain_line();
      case (ph)
        0: begin
          snd_idle = 18;
          rcv_idle = 65;
          write_reg(hle_pkg::CFG_MAX_PAYLOAD, hle_pkg::MAX_PAYLOAD_RST);
          write_reg(hle_pkg::CFG_OUTPUT_CAPACITY, hle_pkg::OUTPUT_CAPACITY_RST);
        end
        1: begin
          // tight limits: plenty of refused octets and trailers
          snd_idle = 65;
          rcv_idle = 18;
          write_reg(hle_pkg::CFG_MAX_PAYLOAD, 16'($urandom_range(1, 16)));
          write_reg(hle_pkg::CFG_OUTPUT_CAPACITY, 16'($urandom_range(4, 40)));
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          write_reg(hle_pkg::CFG_MAX_PAYLOAD, 16'hFFFF);
          write_reg(hle_pkg::CFG_OUTPUT_CAPACITY, 16'($urandom_range(12, 120)));
        end
      endcase

      // Longest run one item can make: escaped last octet plus an FCS whose
      // both octets need escaping. Search a three-octet frame that does it.
      if (ph == 0) begin
        found = 1'b0;
        ha = 8'h00;
        hb = 8'h00;
        hc = 8'h00;
        for (int a = 0; a < 256 && !found; a++) begin
          for (int b = 0; b < 256 && !found; b++) begin
            c2 = crc_x25_byte(crc_x25_byte(hle_pkg::CRC_INIT, 8'(a)), 8'(b));
            for (int k = 0; k < 4 && !found; k++) begin
              c3 = ~crc_x25_byte(c2, RSV_BYTES[k]);
              if (rsv_octet(c3[7:0]) && rsv_octet(c3[15:8])) begin
                ha = 8'(a);
                hb = 8'(b);
                hc = RSV_BYTES[k];
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          send_item(ha, 1'b1, 1'b0);
          send_item(hb, 1'b1, 1'b0);
          send_item(hc, 1'b1, 1'b1);
        end
      end

      goal = n_items + RAND_ITEMS / 3;
      frm = 0;
      while (n_items < goal) begin
        // now and then the sender waits for the line to go quiet
        if (frm % 10 == 5) drain_line();
        if ($urandom_range(9) == 0) begin
          // stray item, any field mix
          send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
          tail_eof = 1'($urandom_range(1));
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            // lean on the escaped octets
            pick = ($urandom_range(3) == 0) ? RSV_BYTES[$urandom_range(3)]
                                            : 8'($urandom_range(255));
            send_item(pick, 1'b1, (k == len - 1) && tail_eof);
          end
          if (len == 0 || !tail_eof) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
        frm++;
      end
      // close whatever a stray item left open before limits change
      send_item(8'h00, 1'b0, 1'b1);
    end

    drain_line();
    $display("checked %0d line beats: %0d frames closed, %0d error beats",
             n_beats, n_frames, n_errs);
    $display("%0d input items under three backpressure mixes, %0d register writes",
             n_items, n_regs);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
